@@ rtl/core/ipow_pkg.sv @@
// shared widths and sequencer types for the integer power block
`default_nettype none

package ipow_pkg;

    // width of the base, exponent and power payload fields on the ports
    localparam int FIELD_WIDTH = 64;

    // arithmetic word width, results wrap modulo 2^DATA_WIDTH (range 8..64)
    localparam int DATA_WIDTH = 64;

    // split of one word into a low and a high half for the shared multiplier
    localparam int LO_WIDTH = (DATA_WIDTH + 1) / 2;
    localparam int HI_WIDTH = DATA_WIDTH - LO_WIDTH;
    localparam int PROD_WIDTH = 2 * LO_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // one multiplier issue per step, then a commit step per exponent bit
    typedef enum logic [2:0] {
        SP_MU_LO,
        SP_MU_X1,
        SP_MU_X2,
        SP_SQ_LO,
        SP_SQ_X,
        SP_COMMIT
    } t_step;

    // where the registered product lands in the cycle after issue
    typedef enum logic [2:0] {
        TG_NONE,
        TG_MU_SET,
        TG_MU_ADD,
        TG_SQ_SET,
        TG_SQ_ADD2
    } t_tag;

endpackage

`default_nettype wire

@@ rtl/core/ipow_if.sv @@
// valid/ready channels for input items and result items
`default_nettype none

interface ipow_in_if
    import ipow_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [FIELD_WIDTH-1:0] base;
    logic [FIELD_WIDTH-1:0] exponent;

    modport source (output valid, output mode, output base, output exponent, input ready);
    modport sink   (input valid, input mode, input base, input exponent, output ready);
endinterface

interface ipow_out_if
    import ipow_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ipow_mul.sv @@
// registered half-word multiplier shared by all partial products
`default_nettype none

module ipow_mul
    import ipow_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [LO_WIDTH-1:0]   i_a,
    input  wire logic [LO_WIDTH-1:0]   i_b,
    output logic      [PROD_WIDTH-1:0] o_p
);

    logic [PROD_WIDTH-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_WIDTH'(i_a) * PROD_WIDTH'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ rtl/core/integer_power_by_squaring.sv @@
// top level: base to the exponent modulo 2^DATA_WIDTH by square-and-multiply
//
//   channel   dir   handshake      payload
//   i_item    in    valid/ready    mode (1), base (64), exponent (64)
//   o_item    out   valid/ready    power (64)
//
// one item at a time: i_item.ready is high only while idle
// per exponent bit, lowest first, up to the highest set bit: a clear bit takes a
// two-part square and a commit, a set bit a three-part multiply, a square and a
// commit, and the top set bit skips its square
// zero exponent or a negative signed exponent go straight to done; a zero base runs
// synchronous active-low reset returns to idle; a result holds until taken
`default_nettype none

module integer_power_by_squaring
    import ipow_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ipow_in_if.sink    i_item,
    ipow_out_if.source o_item
);

    // control
    t_state r_state, n_state;
    t_step  r_step,  n_step;
    t_tag   r_tag,   n_tag;

    // payload
    logic [DATA_WIDTH-1:0] r_b,   n_b;      // running square of the base
    logic [DATA_WIDTH-1:0] r_acc, n_acc;    // running product, then the result
    logic [DATA_WIDTH-1:0] r_exp, n_exp;    // exponent bits not yet consumed
    logic [DATA_WIDTH-1:0] r_sq,  n_sq;     // square being built
    logic [DATA_WIDTH-1:0] r_pr,  n_pr;     // multiply being built

    // shared multiplier
    logic [LO_WIDTH-1:0]   w_mul_a, w_mul_b;
    logic [PROD_WIDTH-1:0] w_prod;

    // operand halves
    logic [LO_WIDTH-1:0]   w_b_lo, w_b_hi, w_acc_lo, w_acc_hi;
    logic [DATA_WIDTH-1:0] w_cross;
    logic [DATA_WIDTH-1:0] w_in_base, w_in_exp, w_exp_nx;

    ipow_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_b_lo   = r_b[LO_WIDTH-1:0];
    assign w_b_hi   = LO_WIDTH'(r_b[DATA_WIDTH-1:LO_WIDTH]);
    assign w_acc_lo = r_acc[LO_WIDTH-1:0];
    assign w_acc_hi = LO_WIDTH'(r_acc[DATA_WIDTH-1:LO_WIDTH]);

    // only the low bits of a cross term survive the wrap
    assign w_cross  = DATA_WIDTH'(w_prod[HI_WIDTH-1:0]);

    assign w_in_base = i_item.base[DATA_WIDTH-1:0];
    assign w_in_exp  = i_item.exponent[DATA_WIDTH-1:0];
    assign w_exp_nx  = r_exp >> 1;

    assign i_item.ready = (r_state == ST_IDLE);
    assign o_item.valid = (r_state == ST_DONE);
    assign o_item.power = FIELD_WIDTH'(r_acc);

    // fold the product issued last cycle into its partial sum
    always_comb begin
        n_sq = r_sq;
        n_pr = r_pr;
        case (r_tag)
            TG_MU_SET:  n_pr = w_prod[DATA_WIDTH-1:0];
            TG_MU_ADD:  n_pr = r_pr + (w_cross << LO_WIDTH);
            TG_SQ_SET:  n_sq = w_prod[DATA_WIDTH-1:0];
            TG_SQ_ADD2: n_sq = r_sq + (w_cross << (LO_WIDTH + 1));
            default: begin
                n_sq = r_sq;
                n_pr = r_pr;
            end
        endcase
    end

    // sequencer: next state, multiplier operands and register updates
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_tag   = TG_NONE;
        n_b     = r_b;
        n_acc   = r_acc;
        n_exp   = r_exp;
        w_mul_a = w_b_lo;
        w_mul_b = w_b_lo;

        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_b   = w_in_base;
                    n_exp = w_in_exp;
                    if (w_in_exp == '0) begin
                        // zero to the zero gives zero, any other base gives one
                        n_acc   = (w_in_base == '0) ? '0 : DATA_WIDTH'(1);
                        n_state = ST_DONE;
                    end else if (i_item.mode && w_in_exp[DATA_WIDTH-1]) begin
                        // negative exponent in signed mode
                        n_acc   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_acc   = DATA_WIDTH'(1);
                        n_step  = w_in_exp[0] ? SP_MU_LO : SP_SQ_LO;
                        n_state = ST_RUN;
                    end
                end
            end

            ST_RUN: begin
                case (r_step)
                    SP_MU_LO: begin
                        w_mul_a = w_acc_lo;
                        w_mul_b = w_b_lo;
                        n_tag   = TG_MU_SET;
                        n_step  = SP_MU_X1;
                    end
                    SP_MU_X1: begin
                        w_mul_a = w_acc_hi;
                        w_mul_b = w_b_lo;
                        n_tag   = TG_MU_ADD;
                        n_step  = SP_MU_X2;
                    end
                    SP_MU_X2: begin
                        w_mul_a = w_acc_lo;
                        w_mul_b = w_b_hi;
                        n_tag   = TG_MU_ADD;
                        // top set bit: the square would never be used
                        n_step  = (w_exp_nx == '0) ? SP_COMMIT : SP_SQ_LO;
                    end
                    SP_SQ_LO: begin
                        w_mul_a = w_b_lo;
                        w_mul_b = w_b_lo;
                        n_tag   = TG_SQ_SET;
                        n_step  = SP_SQ_X;
                    end
                    SP_SQ_X: begin
                        // both cross terms are equal, taken once and doubled
                        w_mul_a = w_b_hi;
                        w_mul_b = w_b_lo;
                        n_tag   = TG_SQ_ADD2;
                        n_step  = SP_COMMIT;
                    end
                    SP_COMMIT: begin
                        n_b   = n_sq;
                        n_acc = r_exp[0] ? n_pr : r_acc;
                        n_exp = w_exp_nx;
                        if (w_exp_nx == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            n_step = w_exp_nx[0] ? SP_MU_LO : SP_SQ_LO;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end

            ST_DONE: begin
                if (o_item.ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= SP_MU_LO;
            r_tag   <= TG_NONE;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_tag   <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b   <= n_b;
        r_acc <= n_acc;
        r_exp <= n_exp;
        r_sq  <= n_sq;
        r_pr  <= n_pr;
    end

endmodule

`default_nettype wire
